// ----- src/fsbfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fsbfa_pkg;
   localparam int FREE_ENTRIES = 64;
   localparam int ADDR_BITS = 48;
   localparam int IDX_BITS = $clog2(FREE_ENTRIES);
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam logic [ADDR_BITS-1:0] ADDR_MASK = '1;

   typedef logic [ADDR_BITS-1:0] addr_type;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE = 2'd1;
   localparam logic [1:0] CMD_RELOC = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
endpackage
`default_nettype wire

// ----- src/file_space_best_fit_allocator_top.sv -----
// A free scans the free table for neighbours to merge with; an allocate scans it for the best fit
// and, if an unused tail is left, scans again to put the tail back; a relocate frees, then allocates.
// An unknown command goes straight to its result; an ignored length or an extent past the
// address space is not inserted. Each pass over the free table reads it through its one read port.
// One command at a time: the next beat is taken the cycle after the result is registered.
// Reset empties the free table and sets the file end to zero; it is synchronous to the clock.
`timescale 1ns / 1ps
`default_nettype none
module file_space_best_fit_allocator_top import fsbfa_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [1:0]     req_command,
   input  wire logic [47:0]    req_block_start,
   input  wire logic [47:0]    req_old_length,
   input  wire logic [47:0]    req_new_length,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [47:0]         rsp_granted_start,
   output logic [1:0]          rsp_status
);
   typedef enum logic [3:0] {
      S_IDLE, S_INS_CHK, S_INS_SCAN, S_INS_PRED, S_INS_SUCC, S_INS_SLOT,
      S_ALC_SCAN, S_ALC_END, S_DONE
   } state_type;

   addr_type mem_start [FREE_ENTRIES];
   addr_type mem_len [FREE_ENTRIES];

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [FREE_ENTRIES-1:0] valid_ff, valid_in;
   addr_type file_end_ff, file_end_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   addr_type rd_start_ff, rd_len_ff;
   addr_type ins_pos_ff, ins_pos_in, ins_len_ff, ins_len_in, need_ff, need_in;
   logic pred_found_ff, pred_found_in, succ_found_ff, succ_found_in;
   logic slot_found_ff, slot_found_in, cur_found_ff, cur_found_in;
   logic best_found_ff, best_found_in;
   logic [IDX_BITS-1:0] pred_idx_ff, pred_idx_in, succ_idx_ff, succ_idx_in;
   logic [IDX_BITS-1:0] slot_idx_ff, slot_idx_in, cur_idx_ff, cur_idx_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;
   addr_type pred_start_ff, pred_start_in, pred_len_ff, pred_len_in;
   addr_type succ_start_ff, succ_start_in, succ_len_ff, succ_len_in;
   addr_type cur_start_ff, cur_start_in, cur_len_ff, cur_len_in;
   addr_type best_start_ff, best_start_in, best_len_ff, best_len_in;
   addr_type granted_ff, granted_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   addr_type rsp_granted_ff, rsp_granted_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic wr_start_en, wr_len_en;
   logic [IDX_BITS-1:0] wr_addr;
   addr_type wr_start_data, wr_len_data;
   logic [ADDR_BITS:0] sum_a, sum_b;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_start = rsp_granted_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      valid_in = valid_ff;
      file_end_in = file_end_ff;
      cnt_in = '0;
      rd_vld_in = 1'b0;
      rd_idx_in = cnt_ff[IDX_BITS-1:0];
      ins_pos_in = ins_pos_ff;
      ins_len_in = ins_len_ff;
      need_in = need_ff;
      pred_found_in = pred_found_ff;
      succ_found_in = succ_found_ff;
      slot_found_in = slot_found_ff;
      cur_found_in = cur_found_ff;
      best_found_in = best_found_ff;
      pred_idx_in = pred_idx_ff;
      succ_idx_in = succ_idx_ff;
      slot_idx_in = slot_idx_ff;
      cur_idx_in = cur_idx_ff;
      best_idx_in = best_idx_ff;
      pred_start_in = pred_start_ff;
      pred_len_in = pred_len_ff;
      succ_start_in = succ_start_ff;
      succ_len_in = succ_len_ff;
      cur_start_in = cur_start_ff;
      cur_len_in = cur_len_ff;
      best_start_in = best_start_ff;
      best_len_in = best_len_ff;
      granted_in = granted_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in = rsp_status_ff;
      wr_start_en = 1'b0;
      wr_len_en = 1'b0;
      wr_addr = cur_idx_ff;
      wr_start_data = ins_pos_ff;
      wr_len_data = ins_len_ff;
      sum_a = '0;
      sum_b = '0;
      case (state_ff)
         S_IDLE: begin
            best_found_in = 1'b0;
            if (req_valid) begin
               granted_in = '0;
               status_in = ST_OK;
               need_in = req_new_length;
               ins_pos_in = req_block_start;
               ins_len_in = req_old_length;
               case (req_command)
                  CMD_ALLOC: state_in = S_ALC_SCAN;
                  CMD_FREE, CMD_RELOC: begin
                     ret_in = (req_command == CMD_RELOC) ? S_ALC_SCAN : S_DONE;
                     if (req_old_length == '0 || req_old_length == ADDR_MASK) begin
                        state_in = (req_command == CMD_RELOC) ? S_ALC_SCAN : S_DONE;
                     end else begin
                        state_in = S_INS_CHK;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_INS_CHK: begin
            best_found_in = 1'b0;
            sum_a = {1'b0, ins_pos_ff} + {1'b0, ins_len_ff};
            pred_found_in = 1'b0;
            succ_found_in = 1'b0;
            slot_found_in = 1'b0;
            cur_found_in = 1'b0;
            cur_start_in = ins_pos_ff;
            cur_len_in = ins_len_ff;
            if (ins_len_ff == '0 || sum_a[ADDR_BITS]) begin
               state_in = ret_ff;
            end else begin
               state_in = S_INS_SCAN;
            end
         end
         S_INS_SCAN: begin
            best_found_in = 1'b0;
            cnt_in = cnt_ff;
            if (cnt_ff < CNT_BITS'(FREE_ENTRIES)) begin
               cnt_in = cnt_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               if (!valid_ff[rd_idx_ff]) begin
                  if (!slot_found_ff) begin
                     slot_found_in = 1'b1;
                     slot_idx_in = rd_idx_ff;
                  end
               end else if (rd_start_ff <= ins_pos_ff) begin
                  if (!pred_found_ff || rd_start_ff > pred_start_ff) begin
                     pred_found_in = 1'b1;
                     pred_idx_in = rd_idx_ff;
                     pred_start_in = rd_start_ff;
                     pred_len_in = rd_len_ff;
                  end
               end else if (!succ_found_ff || rd_start_ff < succ_start_ff) begin
                  succ_found_in = 1'b1;
                  succ_idx_in = rd_idx_ff;
                  succ_start_in = rd_start_ff;
                  succ_len_in = rd_len_ff;
               end
            end else if (cnt_ff == CNT_BITS'(FREE_ENTRIES)) begin
               state_in = S_INS_PRED;
            end
         end
         S_INS_PRED: begin
            best_found_in = 1'b0;
            sum_a = {1'b0, pred_start_ff} + {1'b0, pred_len_ff};
            sum_b = {1'b0, pred_len_ff} + {1'b0, ins_len_ff};
            if (pred_found_ff && sum_a[ADDR_BITS-1:0] == ins_pos_ff) begin
               cur_found_in = 1'b1;
               cur_idx_in = pred_idx_ff;
               cur_start_in = pred_start_ff;
               cur_len_in = sum_b[ADDR_BITS-1:0];
               wr_len_en = 1'b1;
               wr_addr = pred_idx_ff;
               wr_len_data = sum_b[ADDR_BITS-1:0];
            end
            state_in = S_INS_SUCC;
         end
         S_INS_SUCC: begin
            best_found_in = 1'b0;
            sum_a = {1'b0, cur_start_ff} + {1'b0, cur_len_ff};
            sum_b = {1'b0, cur_len_ff} + {1'b0, succ_len_ff};
            if (succ_found_ff && sum_a[ADDR_BITS-1:0] == succ_start_ff) begin
               wr_len_en = 1'b1;
               wr_len_data = sum_b[ADDR_BITS-1:0];
               if (cur_found_ff) begin
                  wr_addr = cur_idx_ff;
                  valid_in[succ_idx_ff] = 1'b0;
               end else begin
                  wr_addr = succ_idx_ff;
                  wr_start_en = 1'b1;
                  wr_start_data = ins_pos_ff;
                  cur_found_in = 1'b1;
               end
            end
            state_in = S_INS_SLOT;
         end
         S_INS_SLOT: begin
            best_found_in = 1'b0;
            if (!cur_found_ff) begin
               if (slot_found_ff) begin
                  wr_start_en = 1'b1;
                  wr_len_en = 1'b1;
                  wr_addr = slot_idx_ff;
                  valid_in[slot_idx_ff] = 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end
            state_in = ret_ff;
         end
         S_ALC_SCAN: begin
            cnt_in = cnt_ff;
            if (cnt_ff < CNT_BITS'(FREE_ENTRIES)) begin
               cnt_in = cnt_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               if (valid_ff[rd_idx_ff] && rd_len_ff >= need_ff &&
                   (!best_found_ff || rd_len_ff < best_len_ff ||
                    (rd_len_ff == best_len_ff && rd_start_ff < best_start_ff))) begin
                  best_found_in = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_start_in = rd_start_ff;
                  best_len_in = rd_len_ff;
               end
            end else if (cnt_ff == CNT_BITS'(FREE_ENTRIES)) begin
               state_in = S_ALC_END;
            end
         end
         S_ALC_END: begin
            state_in = S_DONE;
            if (!best_found_ff) begin
               sum_a = {1'b0, file_end_ff} + {1'b0, need_ff};
               if (sum_a[ADDR_BITS]) begin
                  granted_in = '0;
                  status_in = ST_OVERFLOW;
               end else begin
                  granted_in = file_end_ff;
                  file_end_in = sum_a[ADDR_BITS-1:0];
               end
            end else begin
               sum_a = {1'b0, best_start_ff} + {1'b0, need_ff};
               sum_b = {1'b0, best_len_ff} - {1'b0, need_ff};
               valid_in[best_idx_ff] = 1'b0;
               granted_in = best_start_ff;
               if (best_len_ff > need_ff) begin
                  ins_pos_in = sum_a[ADDR_BITS-1:0];
                  ins_len_in = sum_b[ADDR_BITS-1:0];
                  ret_in = S_DONE;
                  state_in = S_INS_CHK;
               end
            end
         end
         S_DONE: begin
            best_found_in = 1'b0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_granted_in = granted_ff;
               rsp_status_in = status_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_start_en) begin
         mem_start[wr_addr] <= wr_start_data;
      end
      if (wr_len_en) begin
         mem_len[wr_addr] <= wr_len_data;
      end
      rd_start_ff <= mem_start[cnt_ff[IDX_BITS-1:0]];
      rd_len_ff <= mem_len[cnt_ff[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         file_end_ff <= '0;
         cnt_ff <= '0;
         rd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         file_end_ff <= file_end_in;
         cnt_ff <= cnt_in;
         rd_vld_ff <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff <= ret_in;
      rd_idx_ff <= rd_idx_in;
      ins_pos_ff <= ins_pos_in;
      ins_len_ff <= ins_len_in;
      need_ff <= need_in;
      pred_found_ff <= pred_found_in;
      succ_found_ff <= succ_found_in;
      slot_found_ff <= slot_found_in;
      cur_found_ff <= cur_found_in;
      best_found_ff <= best_found_in;
      pred_idx_ff <= pred_idx_in;
      succ_idx_ff <= succ_idx_in;
      slot_idx_ff <= slot_idx_in;
      cur_idx_ff <= cur_idx_in;
      best_idx_ff <= best_idx_in;
      pred_start_ff <= pred_start_in;
      pred_len_ff <= pred_len_in;
      succ_start_ff <= succ_start_in;
      succ_len_ff <= succ_len_in;
      cur_start_ff <= cur_start_in;
      cur_len_ff <= cur_len_in;
      best_start_ff <= best_start_in;
      best_len_ff <= best_len_in;
      granted_ff <= granted_in;
      status_ff <= status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(FREE_ENTRIES))
      else $error("table scan counter out of range");
   a_file_end_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> file_end_ff >= $past(file_end_ff))
      else $error("file end moved backwards");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == ST_OK || rsp_status_ff == ST_FULL ||
                        rsp_status_ff == ST_OVERFLOW))
      else $error("result beat carries an unknown status");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while a command is in progress");
`endif
endmodule
`default_nettype wire
